@@ hw/rtl/glc_pkg.sv @@
// ----------------------------------------------------------------------------
// glc_pkg
// Shared types, character codes and sizes for the gemtext line classifier.
// ----------------------------------------------------------------------------
package glc_pkg;

  localparam int POS_BITS_DEFAULT = 24;
  localparam int FIELD_W          = 24;
  localparam int HEAD_W           = 24;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TICK  = 8'h60;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [2:0] {
    PH_EMPTY = 3'd0,
    PH_EQ    = 3'd1,
    PH_SKIP  = 3'd2,
    PH_BODY  = 3'd3,
    PH_LSKIP = 3'd4,
    PH_URL   = 3'd5,
    PH_DSKIP = 3'd6,
    PH_DESC  = 3'd7
  } scan_phase_t;

  typedef enum logic [2:0] {
    KIND_TEXT    = 3'd0,
    KIND_LINK    = 3'd1,
    KIND_HEADING = 3'd2,
    KIND_LIST    = 3'd3,
    KIND_QUOTE   = 3'd4,
    KIND_PRE     = 3'd5
  } line_kind_t;

  // line start, length, url start, url end, content start, head bytes,
  // scan phase, overflow and last flags
  function automatic int rec_width(input int pos_bits);
    return 5 * pos_bits + HEAD_W + $bits(scan_phase_t) + 2;
  endfunction

endpackage

@@ hw/rtl/glc_front.sv @@
// ----------------------------------------------------------------------------
// glc_front
// Byte scanner: tracks the current line, strips a trailing CR and hands a
// line record to the queue at every line end.
// ----------------------------------------------------------------------------
module glc_front import glc_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEFAULT,
  parameter int REC_W    = rec_width(POS_BITS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       byte_value,
  input  logic             last_byte,
  output logic             rec_valid,
  input  logic             rec_ready,
  output logic [REC_W-1:0] rec_data
);

  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    pos_t              len;
    logic [HEAD_W-1:0] head;
    scan_phase_t       phase;
    pos_t              url_start;
    pos_t              url_end;
    pos_t              content_start;
  } line_t;

  typedef struct packed {
    pos_t              line_start;
    pos_t              len;
    logic [HEAD_W-1:0] head;
    scan_phase_t       phase;
    pos_t              url_start;
    pos_t              url_end;
    pos_t              content_start;
    logic              ovf;
    logic              last;
  } rec_t;

  localparam pos_t ONE   = pos_t'(1);
  localparam pos_t TWO   = pos_t'(2);
  localparam pos_t THREE = pos_t'(3);

  pos_t  byte_position, byte_position_next;
  pos_t  line_start, line_start_next;
  logic  overflow_seen, overflow_seen_next;
  logic  held_return, held_return_next;
  line_t line, line_next, line_taken;
  rec_t  rec;
  logic  accept, line_end;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic line_t take(input line_t s, input pos_t ls, input logic [7:0] c);
    line_t r;
    pos_t  idx;
    pos_t  pos;
    logic  [7:0] h0;
    logic  [7:0] h1;
    r   = s;
    idx = s.len;
    pos = ls + idx;
    if (idx < THREE) begin
      r.head[{idx[1:0], 3'b000} +: 8] = c;
    end
    h0 = r.head[7:0];
    h1 = r.head[15:8];
    unique case (s.phase)
      PH_EMPTY: begin
        priority if (c == CH_HASH || c == CH_GT || c == CH_STAR) r.phase = PH_SKIP;
        else if (c == CH_EQ) r.phase = PH_EQ;
        else r.phase = PH_BODY;
      end
      PH_EQ: r.phase = (c == CH_GT) ? PH_LSKIP : PH_BODY;
      PH_SKIP: begin
        priority if (c == CH_HASH && idx >= ONE && idx < THREE && h0 == CH_HASH &&
                     (idx < TWO || h1 == CH_HASH)) begin
          r.phase = PH_SKIP;
        end else if (!is_blank(c)) begin
          r.content_start = pos;
          r.phase         = PH_BODY;
        end else begin
          r.phase = PH_SKIP;
        end
      end
      PH_LSKIP: begin
        if (!is_blank(c)) begin
          r.url_start = pos;
          r.url_end   = pos + ONE;
          r.phase     = PH_URL;
        end
      end
      PH_URL: begin
        if (is_blank(c)) r.phase = PH_DSKIP;
        else r.url_end = pos + ONE;
      end
      PH_DSKIP: begin
        if (!is_blank(c)) begin
          r.content_start = pos;
          r.phase         = PH_DESC;
        end
      end
      PH_BODY, PH_DESC: r.phase = s.phase;
      default: r.phase = s.phase;
    endcase
    r.len = idx + ONE;
    return r;
  endfunction

  assign in_ready  = rec_ready || !line_end;
  assign accept    = in_valid && in_ready;
  assign line_end  = (byte_value == CH_LF) || last_byte;
  assign rec_valid = in_valid && line_end;

  always_comb begin
    byte_position_next = byte_position + ONE;
    overflow_seen_next = overflow_seen || (byte_position_next == '0);
    line_taken         = line;
    held_return_next   = held_return;
    priority if (byte_value == CH_LF) begin
      held_return_next = 1'b0;
    end else if (byte_value == CH_CR) begin
      if (held_return) line_taken = take(line, line_start, CH_CR);
      held_return_next = 1'b1;
    end else begin
      if (held_return) line_taken = take(line, line_start, CH_CR);
      line_taken       = take(line_taken, line_start, byte_value);
      held_return_next = 1'b0;
    end

    rec.line_start    = line_start;
    rec.len           = line_taken.len;
    rec.head          = line_taken.head;
    rec.phase         = line_taken.phase;
    rec.url_start     = line_taken.url_start;
    rec.url_end       = line_taken.url_end;
    rec.content_start = line_taken.content_start;
    rec.ovf           = overflow_seen_next;
    rec.last          = last_byte;

    line_next       = line_taken;
    line_start_next = line_start;
    if (line_end) begin
      line_next        = '0;
      line_next.phase  = PH_EMPTY;
      held_return_next = 1'b0;
      line_start_next  = byte_position_next;
    end
    if (last_byte) begin
      byte_position_next = '0;
      line_start_next    = '0;
      overflow_seen_next = 1'b0;
    end
  end

  assign rec_data = rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      line_start    <= '0;
      overflow_seen <= 1'b0;
      held_return   <= 1'b0;
      line          <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      line_start    <= line_start_next;
      overflow_seen <= overflow_seen_next;
      held_return   <= held_return_next;
      line          <= line_next;
    end
  end

endmodule

@@ hw/rtl/glc_queue.sv @@
// ----------------------------------------------------------------------------
// glc_queue
// Short first-in first-out queue of line records between scanner and
// classifier.
// ----------------------------------------------------------------------------
module glc_queue import glc_pkg::*; #(
  parameter int WIDTH = rec_width(POS_BITS_DEFAULT),
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        2'b00,
        2'b11:   count <= count;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/glc_back.sv @@
// ----------------------------------------------------------------------------
// glc_back
// Line classifier: turns a line record into a descriptor, tracks
// preformatted mode and the line count, and holds the result register.
// ----------------------------------------------------------------------------
module glc_back import glc_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEFAULT,
  parameter int REC_W    = rec_width(POS_BITS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rec_valid,
  output logic               rec_ready,
  input  logic [REC_W-1:0]   rec_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         kind,
  output logic [1:0]         heading_level,
  output logic [FIELD_W-1:0] text_offset,
  output logic [FIELD_W-1:0] text_length,
  output logic [FIELD_W-1:0] url_offset,
  output logic [FIELD_W-1:0] url_length,
  output logic [FIELD_W-1:0] line_number,
  output logic               overflow
);

  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    pos_t              line_start;
    pos_t              len;
    logic [HEAD_W-1:0] head;
    scan_phase_t       phase;
    pos_t              url_start;
    pos_t              url_end;
    pos_t              content_start;
    logic              ovf;
    logic              last;
  } rec_t;

  localparam pos_t TWO   = pos_t'(2);
  localparam pos_t THREE = pos_t'(3);

  rec_t         rec;
  pos_t         line_end;
  logic [7:0]   b0, b1, b2;
  logic         fence;
  logic         pop;
  logic         pre_mode;
  logic [FIELD_W-1:0] lines_emitted;
  line_kind_t   d_kind;
  logic [1:0]   d_level;
  pos_t         d_toff, d_tlen, d_uoff, d_ulen;

  assign rec       = rec_t'(rec_data);
  assign line_end  = rec.line_start + rec.len;
  assign b0        = rec.head[7:0];
  assign b1        = rec.head[15:8];
  assign b2        = rec.head[23:16];
  assign fence     = (rec.len >= THREE) && (b0 == CH_TICK) && (b1 == CH_TICK) &&
                     (b2 == CH_TICK);
  assign rec_ready = !out_valid || out_ready;
  assign pop       = rec_valid && rec_ready;

  always_comb begin
    d_kind  = KIND_TEXT;
    d_level = 2'd0;
    d_toff  = rec.line_start;
    d_tlen  = rec.len;
    d_uoff  = '0;
    d_ulen  = '0;
    priority if (pre_mode) begin
      d_kind = KIND_PRE;
    end else if (rec.len >= TWO && b0 == CH_EQ && b1 == CH_GT) begin
      if (rec.phase >= PH_URL) begin
        d_kind = KIND_LINK;
        d_uoff = rec.url_start;
        d_ulen = rec.url_end - rec.url_start;
        if (rec.phase == PH_DESC) begin
          d_toff = rec.content_start;
          d_tlen = line_end - rec.content_start;
        end else begin
          d_toff = '0;
          d_tlen = '0;
        end
      end
    end else if (b0 == CH_HASH || b0 == CH_GT ||
                 (rec.len >= TWO && b0 == CH_STAR && b1 == CH_SPACE)) begin
      priority if (b0 == CH_HASH) begin
        d_kind = KIND_HEADING;
        priority if (rec.len >= THREE && b1 == CH_HASH && b2 == CH_HASH) d_level = 2'd3;
        else if (rec.len >= TWO && b1 == CH_HASH) d_level = 2'd2;
        else d_level = 2'd1;
      end else if (b0 == CH_GT) begin
        d_kind = KIND_QUOTE;
      end else begin
        d_kind = KIND_LIST;
      end
      if (rec.phase == PH_BODY) begin
        d_toff = rec.content_start;
        d_tlen = line_end - rec.content_start;
      end else begin
        d_toff = line_end;
        d_tlen = '0;
      end
    end else begin
      d_kind = KIND_TEXT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      pre_mode      <= 1'b0;
      lines_emitted <= '0;
    end else begin
      if (pop) begin
        out_valid <= !fence;
        if (rec.last) begin
          pre_mode      <= 1'b0;
          lines_emitted <= '0;
        end else if (fence) begin
          pre_mode <= !pre_mode;
        end else begin
          lines_emitted <= lines_emitted + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !fence) begin
      kind          <= d_kind;
      heading_level <= d_level;
      text_offset   <= FIELD_W'(d_toff);
      text_length   <= FIELD_W'(d_tlen);
      url_offset    <= FIELD_W'(d_uoff);
      url_length    <= FIELD_W'(d_ulen);
      line_number   <= lines_emitted;
      overflow      <= rec.ovf;
    end
  end

endmodule

@@ hw/rtl/gemtext_line_classifier.sv @@
// ----------------------------------------------------------------------------
// gemtext_line_classifier
// Splits a byte stream into lines and emits one descriptor per line; fence lines emit none.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    byte_value, last_byte
//   out      source     out_valid/out_ready  kind .. overflow
//
// One byte per cycle while in_ready is high; a descriptor passes through the line
// queue and then the result register after its line ends.
// The scanner stalls only when the line queue is full at a line end.
// Reset clears line state, counters, preformatted mode and the queue.
// The result register holds a descriptor while out_ready is low.
// ----------------------------------------------------------------------------
module gemtext_line_classifier import glc_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEFAULT,
  parameter int QDEPTH   = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         byte_value,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         kind,
  output logic [1:0]         heading_level,
  output logic [FIELD_W-1:0] text_offset,
  output logic [FIELD_W-1:0] text_length,
  output logic [FIELD_W-1:0] url_offset,
  output logic [FIELD_W-1:0] url_length,
  output logic [FIELD_W-1:0] line_number,
  output logic               overflow
);

  localparam int REC_W = rec_width(POS_BITS);

  logic             f_valid, f_ready;
  logic [REC_W-1:0] f_data;
  logic             b_valid, b_ready;
  logic [REC_W-1:0] b_data;

  glc_front #(
    .POS_BITS (POS_BITS),
    .REC_W    (REC_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .rec_valid  (f_valid),
    .rec_ready  (f_ready),
    .rec_data   (f_data)
  );

  glc_queue #(
    .WIDTH (REC_W),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  glc_back #(
    .POS_BITS (POS_BITS),
    .REC_W    (REC_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .rec_valid     (b_valid),
    .rec_ready     (b_ready),
    .rec_data      (b_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .heading_level (heading_level),
    .text_offset   (text_offset),
    .text_length   (text_length),
    .url_offset    (url_offset),
    .url_length    (url_length),
    .line_number   (line_number),
    .overflow      (overflow)
  );

endmodule

@@ hw/rtl/glc_checker.sv @@
// ----------------------------------------------------------------------------
// glc_checker
// Port-level checks on the descriptor stream of the line classifier.
// ----------------------------------------------------------------------------
module glc_checker import glc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         kind,
  input logic [1:0]         heading_level,
  input logic [FIELD_W-1:0] text_offset,
  input logic [FIELD_W-1:0] text_length,
  input logic [FIELD_W-1:0] url_offset,
  input logic [FIELD_W-1:0] url_length,
  input logic [FIELD_W-1:0] line_number,
  input logic               overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(line_number) &&
      $stable(text_offset) && $stable(text_length) && $stable(heading_level) &&
      $stable(url_offset) && $stable(url_length) && $stable(overflow))
    else $error("descriptor changed while stalled");

  a_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_HEADING) == (heading_level != 2'd0)))
    else $error("heading level does not match kind");

  a_url: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_LINK) |-> (url_offset == '0) && (url_length == '0))
    else $error("url set on a non-link line");

  a_next_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready ##1 out_valid |->
      (line_number == $past(line_number) + 1'b1) || (line_number == '0))
    else $error("line number skipped");

endmodule

bind gemtext_line_classifier glc_checker u_glc_checker (.*);

@@ tb/gemtext_line_classifier_check.sv @@
// ----------------------------------------------------------------------------
// gemtext_line_classifier_check
// Watches the byte and descriptor channels of the gemtext line classifier.
// Every accepted byte advances a local line scanner that queues the
// descriptor the block owes; every accepted descriptor is compared field by
// field with the oldest queued one.
// ----------------------------------------------------------------------------
module gemtext_line_classifier_check import glc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         byte_value,
  input  logic               last_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         kind,
  input  logic [1:0]         heading_level,
  input  logic [FIELD_W-1:0] text_offset,
  input  logic [FIELD_W-1:0] text_length,
  input  logic [FIELD_W-1:0] url_offset,
  input  logic [FIELD_W-1:0] url_length,
  input  logic [FIELD_W-1:0] line_number,
  input  logic               overflow,
  output int                 fail_count,
  output int                 lines_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = POS_BITS_DEFAULT;

  typedef struct packed {
    line_kind_t         kind;
    logic [1:0]         level;
    logic [FIELD_W-1:0] text_off;
    logic [FIELD_W-1:0] body_len;
    logic [FIELD_W-1:0] url_off;
    logic [FIELD_W-1:0] url_len;
    logic [FIELD_W-1:0] line_no;
    logic               ovf;
  } line_desc_t;

  line_desc_t  line_descs[$];

  bit          pre_mode;
  logic [PW-1:0] doc_pos;
  logic [PW-1:0] line_base;
  logic [PW-1:0] line_bytes;
  logic [HEAD_W-1:0] head;
  bit          cr_held;
  scan_phase_t phase;
  logic [PW-1:0] url_lo;
  logic [PW-1:0] url_hi;
  logic [PW-1:0] body_at;
  logic [FIELD_W-1:0] emitted;
  bit          wrapped;

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  task automatic clear_line_state();
    line_bytes = '0;
    head       = '0;
    cr_held    = 1'b0;
    phase      = PH_EMPTY;
    url_lo     = '0;
    url_hi     = '0;
    body_at    = '0;
  endtask

  task automatic restart_doc();
    pre_mode  = 1'b0;
    doc_pos   = '0;
    line_base = '0;
    emitted   = '0;
    wrapped   = 1'b0;
    clear_line_state();
  endtask

  task automatic scan_byte(input logic [7:0] c);
    logic [PW-1:0] idx;
    logic [PW-1:0] at;
    bit            hash_run;
    idx = line_bytes;
    at  = line_base + idx;
    if (idx < 3) head[8*idx[1:0] +: 8] = c;
    case (phase)
      PH_EMPTY: begin
        if (c == CH_HASH || c == CH_GT || c == CH_STAR) phase = PH_SKIP;
        else if (c == CH_EQ) phase = PH_EQ;
        else phase = PH_BODY;
      end
      PH_EQ: phase = (c == CH_GT) ? PH_LSKIP : PH_BODY;
      PH_SKIP: begin
        hash_run = c == CH_HASH && idx >= 1 && idx < 3 && head[7:0] == CH_HASH &&
                   (idx < 2 || head[15:8] == CH_HASH);
        if (!hash_run && !is_blank(c)) begin
          body_at = at;
          phase   = PH_BODY;
        end
      end
      PH_LSKIP: begin
        if (!is_blank(c)) begin
          url_lo = at;
          url_hi = at + 1'b1;
          phase  = PH_URL;
        end
      end
      PH_URL: begin
        if (is_blank(c)) phase = PH_DSKIP;
        else url_hi = at + 1'b1;
      end
      PH_DSKIP: begin
        if (!is_blank(c)) begin
          body_at = at;
          phase   = PH_DESC;
        end
      end
      default: ;
    endcase
    line_bytes = idx + 1'b1;
  endtask

  task automatic close_line(output bit emit, output line_desc_t d);
    logic [PW-1:0] line_end;
    line_end   = line_base + line_bytes;
    emit       = 1'b1;
    d          = '0;
    d.kind     = KIND_TEXT;
    d.text_off = line_base;
    d.body_len = line_bytes;
    if (line_bytes >= 3 && head == {CH_TICK, CH_TICK, CH_TICK}) begin
      pre_mode = !pre_mode;
      emit     = 1'b0;
    end else begin
      if (pre_mode) begin
        d.kind = KIND_PRE;
      end else if (line_bytes >= 2 && head[7:0] == CH_EQ && head[15:8] == CH_GT) begin
        if (phase >= PH_URL) begin
          d.kind    = KIND_LINK;
          d.url_off = url_lo;
          d.url_len = url_hi - url_lo;
          if (phase == PH_DESC) begin
            d.text_off = body_at;
            d.body_len = line_end - body_at;
          end else begin
            d.text_off = '0;
            d.body_len = '0;
          end
        end
      end else if (head[7:0] == CH_HASH || head[7:0] == CH_GT ||
                   (line_bytes >= 2 && head[7:0] == CH_STAR && head[15:8] == CH_SPACE)) begin
        if (head[7:0] == CH_HASH) begin
          d.kind = KIND_HEADING;
          if (line_bytes >= 3 && head[15:8] == CH_HASH && head[23:16] == CH_HASH)
            d.level = 2'd3;
          else if (line_bytes >= 2 && head[15:8] == CH_HASH) d.level = 2'd2;
          else d.level = 2'd1;
        end else begin
          d.kind = (head[7:0] == CH_GT) ? KIND_QUOTE : KIND_LIST;
        end
        if (phase == PH_BODY) begin
          d.text_off = body_at;
          d.body_len = line_end - body_at;
        end else begin
          d.text_off = line_end;
          d.body_len = '0;
        end
      end
      d.line_no = emitted;
      d.ovf     = wrapped;
      emitted   = emitted + 1'b1;
    end
  endtask

  task automatic take_doc_byte(input logic [7:0] c, input bit fin);
    bit         emit;
    line_desc_t d;
    doc_pos = doc_pos + 1'b1;
    if (doc_pos == 0) wrapped = 1'b1;
    if (c == CH_LF) begin
      cr_held = 1'b0;
    end else if (c == CH_CR) begin
      if (cr_held) scan_byte(CH_CR);
      cr_held = 1'b1;
    end else begin
      if (cr_held) scan_byte(CH_CR);
      cr_held = 1'b0;
      scan_byte(c);
    end
    if (c == CH_LF || fin) begin
      close_line(emit, d);
      if (emit) line_descs.push_back(d);
      clear_line_state();
      line_base = doc_pos;
    end
    if (fin) restart_doc();
  endtask

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want_v,
                             input logic [FIELD_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    line_desc_t want;
    if (rst) begin
      restart_doc();
      line_descs.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (line_descs.size() == 0) begin
          $error("descriptor with none expected: kind %0d, line_number %0d", kind, line_number);
          fail_count++;
        end else begin
          want = line_descs.pop_front();
          check_field("kind", FIELD_W'(want.kind), FIELD_W'(kind));
          check_field("heading_level", FIELD_W'(want.level), FIELD_W'(heading_level));
          check_field("text_offset", want.text_off, text_offset);
          check_field("text_length", want.body_len, text_length);
          check_field("url_offset", want.url_off, url_offset);
          check_field("url_length", want.url_len, url_length);
          check_field("line_number", want.line_no, line_number);
          check_field("overflow", FIELD_W'(want.ovf), FIELD_W'(overflow));
        end
      end
      if (in_valid && in_ready) take_doc_byte(byte_value, last_byte);
    end
    lines_due = line_descs.size();
  end

endmodule

@@ tb/gemtext_line_classifier_test.sv @@
// ----------------------------------------------------------------------------
// gemtext_line_classifier_test
// Feeds gemtext documents byte by byte into the line classifier: a few
// hand-made documents for the corner cases, then random documents of
// well-formed lines with random content mixed with raw noise. Both channels
// idle at random; one burst runs against a long descriptor back-pressure.
// ----------------------------------------------------------------------------
module gemtext_line_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;
  import glc_pkg::*;

  typedef enum int {
    SHAPE_TEXT,
    SHAPE_LINK,
    SHAPE_MARKER,
    SHAPE_HEADING,
    SHAPE_LIST,
    SHAPE_QUOTE,
    SHAPE_NOISE,
    SHAPE_FENCE
  } line_shape_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         byte_value;
  logic               last_byte;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         kind;
  logic [1:0]         heading_level;
  logic [FIELD_W-1:0] text_offset;
  logic [FIELD_W-1:0] text_length;
  logic [FIELD_W-1:0] url_offset;
  logic [FIELD_W-1:0] url_length;
  logic [FIELD_W-1:0] line_number;
  logic               overflow;
  int                 fail_count;
  int                 lines_due;

  logic [7:0]         doc_bytes[$];
  int                 sent;
  int                 hold_cycles;
  bit                 tx_quiet;

  gemtext_line_classifier dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .byte_value(byte_value), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .heading_level(heading_level),
    .text_offset(text_offset), .text_length(text_length),
    .url_offset(url_offset), .url_length(url_length),
    .line_number(line_number), .overflow(overflow)
  );

  gemtext_line_classifier_check chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .byte_value(byte_value), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .heading_level(heading_level),
    .text_offset(text_offset), .text_length(text_length),
    .url_offset(url_offset), .url_length(url_length),
    .line_number(line_number), .overflow(overflow),
    .fail_count(fail_count), .lines_due(lines_due)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: c = 8'("a" + $urandom_range(0, 25));
      5: c = CH_SPACE;
      6: c = CH_TAB;
      7: begin
        case ($urandom_range(0, 4))
          0: c = CH_HASH;
          1: c = CH_EQ;
          2: c = CH_GT;
          3: c = CH_STAR;
          default: c = CH_TICK;
        endcase
      end
      8: c = CH_CR;
      default: c = 8'($urandom_range(0, 255));
    endcase
    if (c == CH_LF) c = CH_STAR;
    return c;
  endfunction

  function automatic logic [7:0] pick_url_char();
    case ($urandom_range(0, 5))
      0: return "/";
      1: return ":";
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
  endtask

  task automatic push_chars(input int n);
    repeat (n) doc_bytes.push_back(pick_char());
  endtask

  task automatic push_blanks(input int n);
    repeat (n) doc_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic add_line(input line_shape_t shape);
    case (shape)
      SHAPE_TEXT: push_chars($urandom_range(0, 12));
      SHAPE_LINK: begin
        doc_bytes.push_back(CH_EQ);
        doc_bytes.push_back(CH_GT);
        push_blanks($urandom_range(0, 2));
        repeat ($urandom_range(1, 8)) doc_bytes.push_back(pick_url_char());
        if ($urandom_range(0, 2) != 0) begin
          push_blanks($urandom_range(1, 2));
          push_chars($urandom_range(0, 8));
        end
      end
      SHAPE_MARKER: begin
        doc_bytes.push_back(CH_EQ);
        doc_bytes.push_back(CH_GT);
        push_blanks($urandom_range(0, 3));
      end
      SHAPE_HEADING: begin
        repeat ($urandom_range(1, 4)) doc_bytes.push_back(CH_HASH);
        push_blanks($urandom_range(0, 2));
        push_chars($urandom_range(0, 8));
      end
      SHAPE_LIST: begin
        doc_bytes.push_back(CH_STAR);
        doc_bytes.push_back($urandom_range(0, 3) != 0 ? CH_SPACE : pick_char());
        push_blanks($urandom_range(0, 1));
        push_chars($urandom_range(0, 8));
      end
      SHAPE_QUOTE: begin
        doc_bytes.push_back(CH_GT);
        push_blanks($urandom_range(0, 2));
        push_chars($urandom_range(0, 8));
      end
      SHAPE_NOISE: repeat ($urandom_range(1, 8)) doc_bytes.push_back(8'($urandom_range(0, 255)));
      default: begin
        repeat (3) doc_bytes.push_back(CH_TICK);
        push_chars($urandom_range(0, 4));
      end
    endcase
  endtask

  task automatic build_doc(input int nlines);
    int          l;
    line_shape_t shape;
    for (l = 0; l < nlines; l++) begin
      shape = ($urandom_range(0, 15) == 0) ? SHAPE_FENCE
                                            : line_shape_t'($urandom_range(0, SHAPE_NOISE));
      add_line(shape);
      if (l < nlines - 1) begin
        case ($urandom_range(0, 5))
          0: doc_bytes.push_back(CH_CR);
          1: repeat (2) doc_bytes.push_back(CH_CR);
          default: ;
        endcase
        doc_bytes.push_back(CH_LF);
      end else begin
        case ($urandom_range(0, 3))
          0: doc_bytes.push_back(CH_LF);
          1: doc_bytes.push_back(CH_CR);
          2: repeat (2) doc_bytes.push_back(CH_CR);
          default: if (doc_bytes.size() == 0) doc_bytes.push_back(CH_LF);
        endcase
      end
    end
  endtask

  // call and return at a falling edge
  task automatic put_byte(input logic [7:0] b, input bit fin);
    int gap;
    gap = (tx_quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    byte_value <= b;
    last_byte  <= fin;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_doc();
    int i;
    for (i = 0; i < doc_bytes.size(); i++) put_byte(doc_bytes[i], i == doc_bytes.size() - 1);
    doc_bytes.delete();
  endtask

  initial begin
    int nlines;
    int doc_idx;
    rst         = 1'b1;
    in_valid    = 1'b0;
    byte_value  = '0;
    last_byte   = 1'b0;
    hold_cycles = 0;
    tx_quiet    = 1'b0;
    sent        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    repeat (3) doc_bytes.push_back(CH_TICK);
    doc_bytes.push_back(CH_LF);
    doc_bytes.push_back(CH_HASH);
    doc_bytes.push_back(CH_LF);
    repeat (3) doc_bytes.push_back(CH_TICK);
    send_doc();
    push_text("=>");
    doc_bytes.push_back(CH_TAB);
    doc_bytes.push_back(CH_LF);
    push_text("##");
    repeat (2) doc_bytes.push_back(CH_CR);
    send_doc();
    push_text("=>u");
    doc_bytes.push_back(CH_LF);
    repeat (3) doc_bytes.push_back(CH_HASH);
    send_doc();
    doc_bytes.push_back(CH_LF);
    send_doc();

    doc_idx = 0;
    while (sent < 1300) begin
      nlines   = $urandom_range(1, 10);
      tx_quiet = ($urandom_range(0, 4) == 0);
      if (doc_idx == 6) begin
        nlines      = 12;
        tx_quiet    = 1'b1;
        hold_cycles = 300;
      end
      if (doc_idx == 12) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (lines_due != 0) @(negedge clk);
      end
      build_doc(nlines);
      send_doc();
      doc_idx++;
    end
    in_valid <= 1'b0;

    while (lines_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && lines_due == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int stall;
    int hold;
    bit rx_calm;
    out_ready = 1'b0;
    rx_calm   = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles != 0) begin
        hold        = hold_cycles;
        hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      stall = (rx_calm || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && hold_cycles == 0);
      @(negedge clk);
    end
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
